// ===== design/grb_pkg.sv =====
// Shared widths, request codes and controller/datapath link types for the gain ramp bank.
package grb_pkg;

  localparam int ReqW          = 2;
  localparam int IdxInW        = 6;
  localparam int TickW         = 15;
  localparam int GainW         = 16;
  localparam int ProdW         = GainW + TickW;
  localparam int NumClassesDef = 51;
  localparam int MaxClasses    = 64;

  localparam logic [GainW-1:0] UnityGain = 16'h8000;

  typedef enum logic [ReqW-1:0] {
    REQ_TICK   = 2'd0,
    REQ_SET    = 2'd1,
    REQ_READ   = 2'd2,
    REQ_REINIT = 2'd3
  } req_type_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic              in_take;
    logic              clear_all;
    logic              set_wr;
    logic              rd_en;
    logic              rd_use_idx;
    logic [IdxInW-1:0] rd_addr;
    logic [IdxInW-1:0] wr_addr;
    logic              eval_ld;
    logic              snap_wr;
    logic              div_init;
    logic              div_step;
    logic              wb_wr;
    logic              out_ld;
  } grb_cmd_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    req_type_e req;
    logic      idx_err;
    logic      delta_zero;
    logic      snap;
    logic      out_free;
  } grb_sts_t;

endpackage

// ===== design/grb_if.sv =====
// Request and response channel interfaces of the gain ramp bank.
interface grb_req_if;
  logic                        valid;
  logic                        ready;
  logic [grb_pkg::ReqW-1:0]    req_type;
  logic [grb_pkg::IdxInW-1:0]  class_id;
  logic [grb_pkg::TickW-1:0]   tick_step;
  logic [grb_pkg::GainW-1:0]   target_gain;
  logic [grb_pkg::TickW-1:0]   ramp_ticks;

  modport source (
    output valid, req_type, class_id, tick_step, target_gain, ramp_ticks,
    input  ready
  );
  modport sink (
    input  valid, req_type, class_id, tick_step, target_gain, ramp_ticks,
    output ready
  );
endinterface

interface grb_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [grb_pkg::GainW-1:0] gain;
  logic                      index_error;

  modport source (
    output valid, gain, index_error,
    input  ready
  );
  modport sink (
    input  valid, gain, index_error,
    output ready
  );
endinterface

// ===== design/grb_dp.sv =====
// Datapath of the gain ramp bank: state memories, multiplier, serial divider, output register.
module grb_dp #(
  parameter int NumClasses = grb_pkg::NumClassesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [grb_pkg::ReqW-1:0]    req_type_i,
  input  logic [grb_pkg::IdxInW-1:0]  class_id_i,
  input  logic [grb_pkg::TickW-1:0]   tick_step_i,
  input  logic [grb_pkg::GainW-1:0]   target_gain_i,
  input  logic [grb_pkg::TickW-1:0]   ramp_ticks_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [grb_pkg::GainW-1:0]   gain_o,
  output logic                        index_error_o,
  input  grb_pkg::grb_cmd_t           cmd_i,
  output grb_pkg::grb_sts_t           sts_o
);

  localparam int IdxInW = grb_pkg::IdxInW;
  localparam int TickW  = grb_pkg::TickW;
  localparam int GainW  = grb_pkg::GainW;
  localparam int ProdW  = grb_pkg::ProdW;
  localparam int IdxW   = (NumClasses > 1) ? $clog2(NumClasses) : 1;
  localparam int TtW    = GainW + TickW;
  localparam logic [IdxInW:0] NumCls = (IdxInW + 1)'(NumClasses);

  // Captured request.
  grb_pkg::req_type_e  req_q;
  logic [IdxInW-1:0]   idx_q;
  logic [TickW-1:0]    delta_q;
  logic [GainW-1:0]    tgt_in_q;
  logic [TickW-1:0]    ramp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      req_q    <= grb_pkg::req_type_e'(req_type_i);
      idx_q    <= class_id_i;
      delta_q  <= tick_step_i;
      tgt_in_q <= target_gain_i;
      ramp_q   <= ramp_ticks_i;
    end
  end

  logic            idx_err;
  logic [IdxW-1:0] idx_a;
  logic [IdxW-1:0] rd_a;
  logic [IdxW-1:0] wr_a;

  assign idx_err = {1'b0, idx_q} >= NumCls;
  assign idx_a   = idx_q[IdxW-1:0];
  assign rd_a    = cmd_i.rd_use_idx ? idx_a : cmd_i.rd_addr[IdxW-1:0];
  assign wr_a    = cmd_i.wr_addr[IdxW-1:0];

  // Target and ticks share one word; current gain has its own memory.
  logic [TtW-1:0]        tt_mem  [NumClasses];
  logic [GainW-1:0]      cur_mem [NumClasses];
  logic [NumClasses-1:0] tt_vld_q;
  logic [NumClasses-1:0] cur_vld_q;

  logic [TtW-1:0]   rd_tt_q;
  logic [GainW-1:0] rd_cur_q;
  logic             rd_ttv_q;
  logic             rd_curv_q;

  // Ramp evaluation registers.
  logic             up_q;
  logic [ProdW-1:0] prod_q;
  logic [GainW-1:0] cur_q;
  logic [GainW-1:0] tgt_q;
  logic [TickW-1:0] left_q;
  logic [TickW-1:0] rem_q;
  logic [GainW-1:0] dq_q;

  // Entries never written since reset or reinit read as unity gain, no ramp.
  logic [GainW-1:0] tgt_e;
  logic [GainW-1:0] cur_e;
  logic [TickW-1:0] left_e;
  logic             snap;
  logic [GainW-1:0] diff;

  assign tgt_e  = rd_ttv_q  ? rd_tt_q[TtW-1:TickW] : grb_pkg::UnityGain;
  assign left_e = rd_ttv_q  ? rd_tt_q[TickW-1:0]   : '0;
  assign cur_e  = rd_curv_q ? rd_cur_q             : grb_pkg::UnityGain;
  assign snap   = !(left_e > delta_q);
  assign diff   = (tgt_e >= cur_e) ? (tgt_e - cur_e) : (cur_e - tgt_e);

  // Restoring division, one quotient bit per step.
  logic [TickW:0]   trial;
  logic [TickW:0]   trial_sub;
  logic             ge;
  logic [TickW-1:0] rem_d;
  logic [GainW-1:0] dq_d;
  logic [GainW-1:0] new_cur;
  logic [TickW-1:0] new_left;

  assign trial     = {rem_q, dq_q[GainW-1]};
  assign trial_sub = trial - {1'b0, left_q};
  assign ge        = trial >= {1'b0, left_q};
  assign rem_d     = ge ? trial_sub[TickW-1:0] : trial[TickW-1:0];
  assign dq_d      = {dq_q[GainW-2:0], ge};
  assign new_cur   = up_q ? (cur_q + dq_q) : (cur_q - dq_q);
  assign new_left  = left_q - delta_q;

  // Write port selection.
  logic             tt_we;
  logic [IdxW-1:0]  tt_wa;
  logic [TtW-1:0]   tt_wd;
  logic             cur_we;
  logic [GainW-1:0] cur_wd;

  always_comb begin
    tt_we  = cmd_i.set_wr || cmd_i.snap_wr || cmd_i.wb_wr;
    tt_wa  = wr_a;
    tt_wd  = {tgt_q, new_left};
    cur_we = cmd_i.snap_wr || cmd_i.wb_wr;
    cur_wd = new_cur;
    if (cmd_i.set_wr) begin
      tt_wa = idx_a;
      tt_wd = {tgt_in_q, ramp_q};
    end else if (cmd_i.snap_wr) begin
      tt_wd  = {tgt_e, {TickW{1'b0}}};
      cur_wd = tgt_e;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tt_we) begin
      tt_mem[tt_wa] <= tt_wd;
    end
    if (cur_we) begin
      cur_mem[wr_a] <= cur_wd;
    end
    if (cmd_i.rd_en) begin
      rd_tt_q   <= tt_mem[rd_a];
      rd_cur_q  <= cur_mem[rd_a];
      rd_ttv_q  <= tt_vld_q[rd_a];
      rd_curv_q <= cur_vld_q[rd_a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tt_vld_q  <= '0;
      cur_vld_q <= '0;
    end else if (cmd_i.clear_all) begin
      tt_vld_q  <= '0;
      cur_vld_q <= '0;
    end else begin
      if (tt_we) begin
        tt_vld_q[tt_wa] <= 1'b1;
      end
      if (cur_we) begin
        cur_vld_q[wr_a] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_ld) begin
      up_q   <= tgt_e >= cur_e;
      prod_q <= ProdW'(diff) * ProdW'(delta_q);
      cur_q  <= cur_e;
      tgt_q  <= tgt_e;
      left_q <= left_e;
    end
    if (cmd_i.div_init) begin
      rem_q <= prod_q[ProdW-1:GainW];
      dq_q  <= prod_q[GainW-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end
  end

  // Output register decouples the response channel from the sequencer.
  logic             out_valid_q;
  logic [GainW-1:0] gain_q;
  logic             err_q;
  logic             addr_req;

  assign addr_req = (req_q == grb_pkg::REQ_SET) || (req_q == grb_pkg::REQ_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      gain_q <= (req_q == grb_pkg::REQ_READ && !idx_err) ? cur_e : '0;
      err_q  <= addr_req && idx_err;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign gain_o        = gain_q;
  assign index_error_o = err_q;

  assign sts_o.req        = req_q;
  assign sts_o.idx_err    = idx_err;
  assign sts_o.delta_zero = (delta_q == '0);
  assign sts_o.snap       = snap;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// ===== design/grb_ctrl.sv =====
// Sequencer of the gain ramp bank: request decode, class walk and divider step control.
module grb_ctrl #(
  parameter int NumClasses = grb_pkg::NumClassesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  grb_pkg::grb_sts_t sts_i,
  output grb_pkg::grb_cmd_t cmd_o
);

  localparam int IdxInW = grb_pkg::IdxInW;
  localparam int IdxW   = (NumClasses > 1) ? $clog2(NumClasses) : 1;
  localparam int StepW  = $clog2(grb_pkg::GainW);
  localparam logic [IdxW-1:0]  LastCls  = IdxW'(NumClasses - 1);
  localparam logic [StepW-1:0] LastStep = StepW'(grb_pkg::GainW - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_DINIT  = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_WB     = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [IdxW-1:0]  cnt_q, cnt_d;
  logic [StepW-1:0] step_q, step_d;
  logic [IdxW-1:0]  cnt_inc;
  logic             cls_last;

  assign cnt_inc  = cnt_q + IdxW'(1);
  assign cls_last = (cnt_q == LastCls);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    cmd_o.wr_addr = IdxInW'(cnt_q);
    cmd_o.rd_addr = IdxInW'(cnt_inc);
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.in_take = in_valid_i;
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_RESP;
        unique case (sts_i.req)
          grb_pkg::REQ_TICK: begin
            if (!sts_i.delta_zero) begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_addr = '0;
              cnt_d         = '0;
              state_d       = S_EVAL;
            end
          end
          grb_pkg::REQ_SET: begin
            cmd_o.set_wr = !sts_i.idx_err;
          end
          grb_pkg::REQ_READ: begin
            cmd_o.rd_en      = !sts_i.idx_err;
            cmd_o.rd_use_idx = 1'b1;
          end
          grb_pkg::REQ_REINIT: begin
            cmd_o.clear_all = 1'b1;
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end
      S_EVAL: begin
        if (sts_i.snap) begin
          cmd_o.snap_wr = 1'b1;
          if (cls_last) begin
            state_d = S_RESP;
          end else begin
            cmd_o.rd_en = 1'b1;
            cnt_d       = cnt_inc;
          end
        end else begin
          cmd_o.eval_ld = 1'b1;
          state_d       = S_DINIT;
        end
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        step_d         = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + StepW'(1);
        if (step_q == LastStep) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        cmd_o.wb_wr = 1'b1;
        if (cls_last) begin
          state_d = S_RESP;
        end else begin
          cmd_o.rd_en = 1'b1;
          cnt_d       = cnt_inc;
          state_d     = S_EVAL;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
    end
  end

  // A response is only loaded when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |-> sts_i.out_free)
    else $error("response loaded while output register busy");

  // The last divider step hands over to the write-back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && step_q == LastStep) |=> (state_q == S_WB))
    else $error("divider did not finish after its last step");

  // An out-of-range set never touches the memories.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.set_wr |-> !sts_i.idx_err)
    else $error("set written with out-of-range class");

  // A ramp evaluation never overlaps a divider step or a memory write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.eval_ld |-> !(cmd_o.div_step || cmd_o.wb_wr || cmd_o.snap_wr))
    else $error("evaluation overlaps another datapath operation");

  // An accepted transaction is decoded in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.in_take |=> (state_q == S_DECODE))
    else $error("accepted request not decoded");

endmodule

// ===== design/gain_ramp_bank_unit.sv =====
// Top level of the gain ramp bank: request and response channels around sequencer and datapath.
//
// The bank holds one linear gain ramp per sound class. Requests arrive on the
// req_i channel and each produces exactly one transaction on rsp_o. A tick
// request advances every class by tick_step, a set request loads a target
// and a ramp length for one class, a read request returns the current gain of
// one class, and a reinit request puts every class back to unity gain (1.0 in
// Q1.15) with no ramp pending. Set and read with a class index at or above
// the class count change nothing and answer with index_error high.
//
// Set, read and reinit put their response on rsp_o two cycles after acceptance,
// so they go at one every three cycles. A tick answers 2 + 19 * NumClasses
// cycles after acceptance when every class is ramping (3 + 19 * NumClasses per
// tick): each ramping class costs one cycle to evaluate and multiply, one to
// load the divider, sixteen for the bit-serial division and one to write back.
// A class whose ramp ends or is idle costs one cycle. One request is worked on
// at a time; the next is accepted as soon as the response sits in the output
// register. Reset marks every class as unwritten, so all read as unity gain.
// A stalled receiver holds the response in the output register; the bank then
// waits before answering the next request.
module gain_ramp_bank_unit #(
  parameter int NumClasses = grb_pkg::NumClassesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  grb_req_if.sink    req_i,
  grb_rsp_if.source  rsp_o
);

  grb_pkg::grb_cmd_t cmd;
  grb_pkg::grb_sts_t sts;

  grb_ctrl #(
    .NumClasses (NumClasses)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  grb_dp #(
    .NumClasses (NumClasses)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_type_i    (req_i.req_type),
    .class_id_i    (req_i.class_id),
    .tick_step_i   (req_i.tick_step),
    .target_gain_i (req_i.target_gain),
    .ramp_ticks_i  (req_i.ramp_ticks),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .gain_o        (rsp_o.gain),
    .index_error_o (rsp_o.index_error),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule
